### hw/rtl/fsq_pkg.sv
// Shared types and codes for the sortable FIFO queue.
// Request kinds, result status codes, controller states and the result record.
// No dependencies; imported by fsq_ctrl and the top level.
`timescale 1ns / 1ps
`default_nettype none

package fsq_pkg;

  // Request kinds carried on the input tuser field.
  typedef enum logic [1:0] {
    REQ_ENQ  = 2'd0,
    REQ_DEQ  = 2'd1,
    REQ_SORT = 2'd2
  } req_kind_t;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // Controller states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_DEQ,
    S_KEY,
    S_CMP,
    S_PUT
  } ctrl_state_t;

  localparam int unsigned VALUE_W = 32;
  localparam int unsigned FILL_W  = 5;

  typedef struct packed {
    logic signed [VALUE_W-1:0] out_value;
    status_t                   status;
    logic [FILL_W-1:0]         fill_count;
  } result_t;

endpackage

`default_nettype wire

### hw/rtl/fsq_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Width and depth are parameters; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

module fsq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### hw/rtl/fsq_ctrl.sv
// Queue controller: head pointer, fill count and the insertion-sort walker.
// Drives the value RAM (fsq_ram) and hands one result per request to the top level.
// Depends on fsq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fsq_ctrl
  import fsq_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     req_valid,
  output      logic                     req_ready,
  input  wire logic [1:0]               req_kind,
  input  wire logic [VALUE_W-1:0]       req_value,
  input  wire logic                     out_free,
  output      logic                     res_load,
  output      result_t                  res,
  output      logic                     mem_we,
  output      logic [$clog2(DEPTH)-1:0] mem_waddr,
  output      logic [VALUE_W-1:0]       mem_wdata,
  output      logic                     mem_re,
  output      logic [$clog2(DEPTH)-1:0] mem_raddr,
  input  wire logic [VALUE_W-1:0]       mem_rdata
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  ctrl_state_t        state, state_next;
  logic [AW-1:0]      head, head_next;
  logic [CW-1:0]      count, count_next;
  logic [CW-1:0]      i, i_next;
  logic [CW-1:0]      j, j_next;
  logic signed [VALUE_W-1:0] key, key_next;
  logic [CW-1:0]      i_inc;

  // Physical slot of a queue position: head plus offset, wrapped once.
  function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] hd,
                                            input logic [CW-1:0] pos);
    logic [AW:0] sum;
    sum = {1'b0, hd} + (AW+1)'(pos);
    if (sum >= (AW+1)'(DEPTH)) begin
      sum = sum - (AW+1)'(DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      head  <= '0;
      count <= '0;
    end else begin
      state <= state_next;
      head  <= head_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    i   <= i_next;
    j   <= j_next;
    key <= key_next;
  end

  assign req_ready = (state == S_IDLE) && out_free;
  assign i_inc     = i + CW'(1);

  always_comb begin
    state_next     = state;
    head_next      = head;
    count_next     = count;
    i_next         = i;
    j_next         = j;
    key_next       = key;
    mem_we         = 1'b0;
    mem_waddr      = head;
    mem_wdata      = key;
    mem_re         = 1'b0;
    mem_raddr      = head;
    res_load       = 1'b0;
    res.out_value  = '0;
    res.status     = ST_OK;

    unique case (state)
      S_IDLE: begin
        if (req_valid && req_ready) begin
          unique case (req_kind)
            REQ_ENQ: begin
              res_load = 1'b1;
              if (count == CW'(DEPTH)) begin
                res.status = ST_FULL;
              end else begin
                mem_we     = 1'b1;
                mem_waddr  = slot_of(head, count);
                mem_wdata  = req_value;
                count_next = count + CW'(1);
              end
            end
            REQ_DEQ: begin
              if (count == '0) begin
                res_load   = 1'b1;
                res.status = ST_EMPTY;
              end else begin
                mem_re     = 1'b1;
                mem_raddr  = head;
                state_next = S_DEQ;
              end
            end
            REQ_SORT: begin
              if (count < CW'(2)) begin
                res_load = 1'b1;
              end else begin
                mem_re     = 1'b1;
                mem_raddr  = slot_of(head, CW'(1));
                i_next     = CW'(1);
                state_next = S_KEY;
              end
            end
            default: begin
              res_load = 1'b1;
            end
          endcase
        end
      end

      S_DEQ: begin
        res_load      = 1'b1;
        res.out_value = mem_rdata;
        count_next    = count - CW'(1);
        head_next     = (head == AW'(DEPTH - 1)) ? '0 : head + AW'(1);
        state_next    = S_IDLE;
      end

      S_KEY: begin
        key_next   = mem_rdata;
        j_next     = i;
        mem_re     = 1'b1;
        mem_raddr  = slot_of(head, i - CW'(1));
        state_next = S_CMP;
      end

      S_CMP: begin
        mem_we    = 1'b1;
        mem_waddr = slot_of(head, j);
        if ($signed(mem_rdata) > key) begin
          // Shift the larger neighbor up one place and keep walking down.
          mem_wdata = mem_rdata;
          j_next    = j - CW'(1);
          if (j == CW'(1)) begin
            state_next = S_PUT;
          end else begin
            mem_re    = 1'b1;
            mem_raddr = slot_of(head, j - CW'(2));
          end
        end else begin
          mem_wdata = key;
          if (i_inc == count) begin
            res_load   = 1'b1;
            state_next = S_IDLE;
          end else begin
            mem_re     = 1'b1;
            mem_raddr  = slot_of(head, i_inc);
            i_next     = i_inc;
            state_next = S_KEY;
          end
        end
      end

      S_PUT: begin
        mem_we    = 1'b1;
        mem_waddr = head;
        mem_wdata = key;
        if (i_inc == count) begin
          res_load   = 1'b1;
          state_next = S_IDLE;
        end else begin
          mem_re     = 1'b1;
          mem_raddr  = slot_of(head, i_inc);
          i_next     = i_inc;
          state_next = S_KEY;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase

    res.fill_count = FILL_W'(count_next);
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("fill count exceeds depth");

  a_no_rw_collide: assert property (@(posedge clk) disable iff (rst)
    (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
    else $error("read and write hit the same slot in one cycle");

  a_result_room: assert property (@(posedge clk) disable iff (rst)
    res_load |-> out_free)
    else $error("result produced while output register is occupied");

  a_full_status: assert property (@(posedge clk) disable iff (rst)
    (res_load && (res.status == ST_FULL)) |-> (count == CW'(DEPTH)))
    else $error("full status given while store has room");

  a_deq_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == S_DEQ) |-> (count != '0))
    else $error("dequeue read started on an empty store");

endmodule

`default_nettype wire

### hw/rtl/sortable_fifo_queue.sv
// Top level of the sortable FIFO queue: stream ports and the result register.
// Instantiates fsq_ctrl and fsq_ram; depends on fsq_pkg.
//
//   Channel   Dir  Signals                        Contents
//   request   in   s_tvalid s_tready s_tdata s_tuser   value, request kind
//   result    out  m_tvalid m_tready m_tdata m_tuser   value+fill count, status
//
// An enqueue, a refused request, an unused kind and a sort of fewer than two
// values load their result into the result register as they are accepted. A dequeue
// first reads the head value through the registered read port of the value RAM. A
// sort runs an insertion sort over the RAM, reading each key and shifting larger
// values up one place until the key's spot is found.
// Reset clears the head pointer, the fill count and the result register; the
// RAM contents are not cleared, and no read ever reaches an unwritten slot.
// A new request is taken only when the controller is idle and the result
// register is empty or being emptied in the same cycle, so a stalled result
// holds intake back.
`timescale 1ns / 1ps
`default_nettype none

module sortable_fifo_queue
  import fsq_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // Request channel.
  input  wire logic        s_tvalid,
  output      logic        s_tready,
  input  wire logic [31:0] s_tdata,   // [31:0] in_value
  input  wire logic [1:0]  s_tuser,   // [1:0] req_type
  // Result channel.
  output      logic        m_tvalid,
  input  wire logic        m_tready,
  output      logic [39:0] m_tdata,   // [31:0] out_value, [36:32] fill_count, rest zero
  output      logic [1:0]  m_tuser    // [1:0] status
);

  localparam int unsigned AW = $clog2(DEPTH);

  logic               out_valid;
  result_t            out_res;
  logic               out_free;
  logic               res_load;
  result_t            res;
  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic [VALUE_W-1:0] mem_wdata;
  logic               mem_re;
  logic [AW-1:0]      mem_raddr;
  logic [VALUE_W-1:0] mem_rdata;

  // The result register may take a new result when it is empty or when its
  // current contents are being taken in this cycle.
  assign out_free = !out_valid || m_tready;

  fsq_ctrl #(
    .DEPTH(DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (s_tvalid),
    .req_ready (s_tready),
    .req_kind  (s_tuser),
    .req_value (s_tdata),
    .out_free  (out_free),
    .res_load  (res_load),
    .res       (res),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  fsq_ram #(
    .WIDTH(VALUE_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Result register: valid bit under reset, payload loaded with each result.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_load) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_res <= res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {3'b000, out_res.fill_count, out_res.out_value};
  assign m_tuser  = out_res.status;

endmodule

`default_nettype wire

### tb/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for the sortable FIFO queue: it streams enqueue, dequeue,
// sort and unused requests and checks every result against a shadow circular buffer.
// Depends on fsq_pkg and sortable_fifo_queue.

module tb;
  import fsq_pkg::*;

  localparam int QDEPTH = 16;
  localparam int CLK_PERIOD = 12;
  localparam int RESET_CYCLES = 11;
  localparam int DIRECTED_COUNT = 25;
  localparam int TOTAL_REQUESTS = 1450;
  localparam int PHASE_LEN = 484;
  localparam int SETTLE_CYCLES = 200;
  localparam int TIMEOUT_CYCLES = 1_000_000;

  // Request kind that the block treats as a no-op.
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  // Idle percentages per phase: sender first mostly busy, then mostly idle, then never idle.
  localparam int SEND_IDLE [3] = '{11, 87, 0};
  localparam int RECV_IDLE [3] = '{87, 11, 0};

  localparam logic [31:0] FILL_VALUES [16] = '{
    32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0000_0000,
    32'h0000_0001, 32'h0000_0005, 32'hFFFF_FFFB, 32'h0000_0005,
    32'h5555_5555, 32'hAAAA_AAAA, 32'h0001_0000, 32'h8000_0001,
    32'h7FFF_FFFE, 32'h0000_0003, 32'hFFFF_0000, 32'h0000_0002
  };

  typedef struct {
    logic [1:0]  kind;
    logic [31:0] value;
    int          phase;
    bit          drain;
  } request_item_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;
  logic [1:0]  m_tuser;

  request_item_t request_backlog[$];
  result_t       pending_results[$];
  logic          req_fire = 1'b0;
  int            cur_phase = 0;
  int            errors = 0;

  // Shadow copy of the queue contents.
  logic signed [31:0] shadow_store [QDEPTH];
  int                 shadow_head = 0;
  int                 shadow_count = 0;

  sortable_fifo_queue #(.DEPTH(QDEPTH)) uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Stable ascending sort of the stored values, head to tail.
  function automatic void shadow_sort();
    logic signed [31:0] vals [QDEPTH];
    logic signed [31:0] key;
    int i, j;
    for (i = 0; i < shadow_count; i++) vals[i] = shadow_store[(shadow_head + i) % QDEPTH];
    for (i = 1; i < shadow_count; i++) begin
      key = vals[i];
      j = i;
      while (j > 0 && vals[j-1] > key) begin
        vals[j] = vals[j-1];
        j--;
      end
      vals[j] = key;
    end
    for (i = 0; i < shadow_count; i++) shadow_store[(shadow_head + i) % QDEPTH] = vals[i];
  endfunction

  function automatic result_t shadow_request(logic [1:0] kind, logic [31:0] value);
    result_t r;
    r.out_value = '0;
    r.status = ST_OK;
    if (kind == REQ_ENQ) begin
      if (shadow_count >= QDEPTH) begin
        r.status = ST_FULL;
      end else begin
        shadow_store[(shadow_head + shadow_count) % QDEPTH] = value;
        shadow_count++;
      end
    end else if (kind == REQ_DEQ) begin
      if (shadow_count == 0) begin
        r.status = ST_EMPTY;
      end else begin
        r.out_value = shadow_store[shadow_head];
        shadow_head = (shadow_head + 1) % QDEPTH;
        shadow_count--;
      end
    end else if (kind == REQ_SORT) begin
      shadow_sort();
    end
    r.fill_count = 5'(shadow_count);
    return r;
  endfunction

  function automatic logic [31:0] random_value();
    logic [31:0] v;
    case ($urandom_range(9))
      5, 6:    v = $urandom_range(16) - 8;
      7:       v = 32'h8000_0000 + $urandom_range(3);
      8:       v = 32'h7FFF_FFFF - $urandom_range(3);
      9:       v = $urandom | 32'h8000_0000;
      default: v = $urandom;
    endcase
    return v;
  endfunction

  // Phase and the drain pause follow from the position in the backlog.
  task automatic add_request(input logic [1:0] kind, input logic [31:0] value);
    request_item_t it;
    int idx;
    idx = request_backlog.size();
    it.kind = kind;
    it.value = value;
    it.phase = (idx < PHASE_LEN) ? 0 : (idx < 2 * PHASE_LEN) ? 1 : 2;
    it.drain = (idx == DIRECTED_COUNT) || (idx > 0 && idx % PHASE_LEN == 0);
    request_backlog.push_back(it);
  endtask

  // Inputs change on the falling edge.
  always @(negedge clk) begin : request_driver
    request_item_t it;
    if (rst) begin
      s_tvalid <= 1'b0;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= RECV_IDLE[cur_phase]);
      if (!s_tvalid || req_fire) begin
        if (request_backlog.size() == 0) begin
          s_tvalid <= 1'b0;
        end else if (request_backlog[0].drain && pending_results.size() != 0) begin
          s_tvalid <= 1'b0;
        end else if ($urandom_range(99) < SEND_IDLE[request_backlog[0].phase]) begin
          s_tvalid <= 1'b0;
        end else begin
          it = request_backlog.pop_front();
          s_tvalid <= 1'b1;
          s_tdata <= it.value;
          s_tuser <= it.kind;
          cur_phase <= it.phase;
        end
      end
    end
  end

  // Handshakes are sampled on the rising edge.
  always @(posedge clk) begin : result_monitor
    result_t exp_r;
    req_fire <= !rst && s_tvalid && s_tready;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (pending_results.size() == 0) begin
          errors++;
          $display("%0t: unexpected result: expected none, actual value %0d status %0d fill %0d",
                   $time, $signed(m_tdata[31:0]), m_tuser, m_tdata[36:32]);
        end else begin
          exp_r = pending_results.pop_front();
          if ($signed(m_tdata[31:0]) !== exp_r.out_value) begin
            errors++;
            $display("%0t: out_value mismatch: expected %0d, actual %0d",
                     $time, exp_r.out_value, $signed(m_tdata[31:0]));
          end
          if (m_tuser !== exp_r.status) begin
            errors++;
            $display("%0t: status mismatch: expected %0d, actual %0d",
                     $time, exp_r.status, m_tuser);
          end
          if (m_tdata[36:32] !== exp_r.fill_count) begin
            errors++;
            $display("%0t: fill_count mismatch: expected %0d, actual %0d",
                     $time, exp_r.fill_count, m_tdata[36:32]);
          end
        end
      end
      if (s_tvalid && s_tready) begin
        pending_results.push_back(shadow_request(s_tuser, s_tdata));
      end
    end
  end

  initial begin : stimulus
    int n, seg_left, enq_bias, roll;
    logic [1:0] kind;

    // Empty store: refused dequeue, trivial sorts of zero and one values, unused kind.
    add_request(REQ_DEQ, 32'hFFFF_FFFF);
    add_request(REQ_SORT, 32'h0);
    add_request(REQ_ENQ, 32'h8000_0000);
    add_request(REQ_SORT, 32'h1234_5678);
    add_request(REQ_DEQ, 32'h0);
    add_request(REQ_UNUSED, 32'hDEAD_BEEF);
    // Fill to the brim, refuse one more, then sort a full store and dequeue its head.
    for (n = 0; n < QDEPTH; n++) add_request(REQ_ENQ, FILL_VALUES[n]);
    add_request(REQ_ENQ, 32'h0000_0007);
    add_request(REQ_SORT, 32'h0);
    add_request(REQ_DEQ, 32'h0);

    // Random part in segments that lean toward filling, draining or neither.
    seg_left = 0;
    enq_bias = 50;
    for (n = DIRECTED_COUNT; n < TOTAL_REQUESTS; n++) begin
      if (seg_left == 0) begin
        seg_left = $urandom_range(60, 10);
        case ($urandom_range(2))
          0:       enq_bias = 25;
          1:       enq_bias = 50;
          default: enq_bias = 80;
        endcase
      end
      seg_left--;
      roll = $urandom_range(99);
      if (roll < 4) kind = REQ_UNUSED;
      else if (roll < 14) kind = REQ_SORT;
      else if ($urandom_range(99) < enq_bias) kind = REQ_ENQ;
      else kind = REQ_DEQ;
      add_request(kind, random_value());
    end

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (request_backlog.size() != 0 || s_tvalid || pending_results.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (errors == 0) begin
      $display("sortable_fifo_queue test passed");
    end else begin
      $display("sortable_fifo_queue test failed");
    end
    $finish;
  end

  initial begin : watchdog
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("sortable_fifo_queue test failed");
    $finish;
  end

endmodule
